// ===== rtl/sasg_pkg.sv =====
// Shared types and constants of the six-axis step generator.
`default_nettype none

package sasg_pkg;

    // Number of axes; the payload has one port per axis, so this is fixed.
    localparam int AXES     = 6;
    // Width of a signed axis position.
    localparam int POS_BITS = 32;

    // Operation codes of an input item.
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    // Per-cycle commands from the top level to every axis lane.
    typedef struct packed {
        logic load;     // preset accumulator, take new step count
        logic advance;  // run one Bresenham tick
        logic clear;    // last tick of the move: zero the move state
    } lane_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/sasg_lane.sv =====
// One axis lane: accumulator, step count and position of a single axis.
`default_nettype none

module sasg_lane #(
    parameter int COUNT_BITS = 24
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire  sasg_pkg::lane_ctl_t        ctl,
    input  wire  [COUNT_BITS-1:0]            steps_in,
    input  wire  [COUNT_BITS-1:0]            preset,
    input  wire  [COUNT_BITS-1:0]            event_total,
    input  wire                              dir_neg,
    output logic                             fire,
    output logic signed [sasg_pkg::POS_BITS-1:0] pos
);
    import sasg_pkg::*;

    logic [COUNT_BITS-1:0] acc_reg;
    logic [COUNT_BITS-1:0] acc_next;
    logic [COUNT_BITS-1:0] steps_reg;
    logic [POS_BITS-1:0]   pos_reg;
    logic [POS_BITS-1:0]   pos_next;
    logic [COUNT_BITS:0]   sum;
    logic [COUNT_BITS:0]   diff;

    // Accumulator never exceeds the event total, so the sum fits one extra bit.
    assign sum  = {1'b0, acc_reg} + {1'b0, steps_reg};
    assign diff = sum - {1'b0, event_total};
    assign fire = (sum > {1'b0, event_total});

    assign acc_next = fire ? diff[COUNT_BITS-1:0] : sum[COUNT_BITS-1:0];
    assign pos_next = dir_neg ? (pos_reg - POS_BITS'(1)) : (pos_reg + POS_BITS'(1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg   <= '0;
            steps_reg <= '0;
            pos_reg   <= '0;
        end else if (ctl.load) begin
            acc_reg   <= preset;
            steps_reg <= steps_in;
        end else if (ctl.advance) begin
            // Position moves even when the step pulse is masked by a limit.
            if (fire) begin
                pos_reg <= pos_next;
            end
            if (ctl.clear) begin
                acc_reg   <= '0;
                steps_reg <= '0;
            end else begin
                acc_reg <= acc_next;
            end
        end
    end

    assign pos = signed'(pos_reg);

endmodule

`default_nettype wire

// ===== rtl/sasg_merge.sv =====
// Merge stage: event total and preset for a load, masked step bits for a tick.
`default_nettype none

module sasg_merge #(
    parameter int COUNT_BITS = 24
) (
    input  wire  [sasg_pkg::AXES-1:0][COUNT_BITS-1:0] steps,
    input  wire  [sasg_pkg::AXES-1:0]                 fire,
    input  wire  [sasg_pkg::AXES-1:0]                 limit_bits,
    input  wire                                       limit_enable,
    input  wire                                       advance,
    output logic [COUNT_BITS-1:0]                     top,
    output logic [COUNT_BITS-1:0]                     preset,
    output logic [sasg_pkg::AXES-1:0]                 step_bits
);
    import sasg_pkg::*;

    logic [AXES-1:0] blocked;

    always_comb begin
        top = '0;
        for (int i = 0; i < AXES; i++) begin
            if (steps[i] > top) begin
                top = steps[i];
            end
        end
    end

    // Half the event total, but one when the move is a single tick.
    assign preset = (top == COUNT_BITS'(1)) ? COUNT_BITS'(1) : (top >> 1);

    assign blocked   = limit_enable ? limit_bits : '0;
    assign step_bits = advance ? (fire & ~blocked) : '0;

endmodule

`default_nettype wire

// ===== rtl/six_axis_bresenham_step_generator.sv =====
// Top level of the six-axis Bresenham step generator.
`default_nettype none

// Six-axis Bresenham step generator. A load transfer (operation = 1) starts a
// move from six step counts and direction bits; the move lasts as many ticks
// as the largest count. Each tick transfer (operation = 0) advances all six
// axis lanes at once and returns the step pulse requests, masked by the live
// limit inputs when limit_enable is set. Every input transfer yields exactly
// one result transfer carrying step bits, directions, busy flag and the six
// signed positions, which wrap modulo 2^32 and are kept across moves.
// Rate: one item per clock cycle while results are taken, each result held in
// an output register. The rate is set by the per-lane accumulate, compare and
// subtract loop around each lane's accumulator register, and by the single
// output register stage: s_ready stays high while the output register is
// empty or is being taken in the same cycle. limit_enable is written through
// cfg_wr_en and cfg_wr_data and must only change while the block is idle.

module six_axis_bresenham_step_generator #(
    parameter int COUNT_BITS = 24
) (
    input  wire                               aclk,
    input  wire                               aresetn,
    // configuration
    input  wire                               cfg_wr_en,
    input  wire                               cfg_wr_data,
    // input channel
    input  wire                               s_valid,
    output logic                              s_ready,
    input  wire                               s_operation,
    input  wire  [COUNT_BITS-1:0]             s_steps_x,
    input  wire  [COUNT_BITS-1:0]             s_steps_y,
    input  wire  [COUNT_BITS-1:0]             s_steps_z,
    input  wire  [COUNT_BITS-1:0]             s_steps_a,
    input  wire  [COUNT_BITS-1:0]             s_steps_b,
    input  wire  [COUNT_BITS-1:0]             s_steps_c,
    input  wire  [sasg_pkg::AXES-1:0]         s_direction_bits,
    input  wire  [sasg_pkg::AXES-1:0]         s_limit_bits,
    // result channel
    output logic                              m_valid,
    input  wire                               m_ready,
    output logic [sasg_pkg::AXES-1:0]         m_step_bits,
    output logic [sasg_pkg::AXES-1:0]         m_dir_bits,
    output logic                              m_busy_res,
    output logic signed [sasg_pkg::POS_BITS-1:0] m_pos_x,
    output logic signed [sasg_pkg::POS_BITS-1:0] m_pos_y,
    output logic signed [sasg_pkg::POS_BITS-1:0] m_pos_z,
    output logic signed [sasg_pkg::POS_BITS-1:0] m_pos_a,
    output logic signed [sasg_pkg::POS_BITS-1:0] m_pos_b,
    output logic signed [sasg_pkg::POS_BITS-1:0] m_pos_c
);
    import sasg_pkg::*;

    // Move state shared by all lanes
    logic                  limit_enable_reg;
    logic [AXES-1:0]       move_dirs_reg;
    logic [COUNT_BITS-1:0] event_total_reg;
    logic [COUNT_BITS-1:0] ticks_left_reg;

    // Output register
    logic                  m_valid_reg;
    logic [AXES-1:0]       step_bits_reg;
    logic [AXES-1:0]       dir_bits_reg;
    logic                  busy_reg;

    logic                  accept;
    logic                  do_load;
    logic                  do_tick;
    logic                  last_tick;
    lane_ctl_t             lane_ctl;

    logic [AXES-1:0][COUNT_BITS-1:0] steps_arr;
    logic [AXES-1:0]                 fire;
    logic [POS_BITS-1:0]             pos_arr [AXES];
    logic [COUNT_BITS-1:0]           top;
    logic [COUNT_BITS-1:0]           preset;
    logic [AXES-1:0]                 step_bits;

    // Accept whenever the output register is free or drains this cycle.
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign do_load   = accept && (s_operation == OP_LOAD);
    // Ticks with nothing left to do change no move or lane state.
    assign do_tick   = accept && (s_operation == OP_TICK) && (ticks_left_reg != '0);
    assign last_tick = (ticks_left_reg == COUNT_BITS'(1));

    assign lane_ctl.load    = do_load;
    assign lane_ctl.advance = do_tick;
    assign lane_ctl.clear   = do_tick && last_tick;

    // Gather the per-axis step counts into lane order.
    assign steps_arr[0] = s_steps_x;
    assign steps_arr[1] = s_steps_y;
    assign steps_arr[2] = s_steps_z;
    assign steps_arr[3] = s_steps_a;
    assign steps_arr[4] = s_steps_b;
    assign steps_arr[5] = s_steps_c;

    // One lane per axis, all advancing on the same tick.
    for (genvar g = 0; g < AXES; g++) begin : g_lane
        sasg_lane #(
            .COUNT_BITS (COUNT_BITS)
        ) u_lane (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctl         (lane_ctl),
            .steps_in    (steps_arr[g]),
            .preset      (preset),
            .event_total (event_total_reg),
            .dir_neg     (move_dirs_reg[g]),
            .fire        (fire[g]),
            .pos         (pos_arr[g])
        );
    end

    // Event total and preset for loads, limit masking of step pulses for ticks.
    sasg_merge #(
        .COUNT_BITS (COUNT_BITS)
    ) u_merge (
        .steps        (steps_arr),
        .fire         (fire),
        .limit_bits   (s_limit_bits),
        .limit_enable (limit_enable_reg),
        .advance      (do_tick),
        .top          (top),
        .preset       (preset),
        .step_bits    (step_bits)
    );

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_enable_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            limit_enable_reg <= cfg_wr_data;
        end
    end

    // Move state: a load replaces any move in progress at once.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            move_dirs_reg   <= '0;
            event_total_reg <= '0;
            ticks_left_reg  <= '0;
        end else if (do_load) begin
            move_dirs_reg   <= s_direction_bits;
            event_total_reg <= top;
            ticks_left_reg  <= top;
        end else if (do_tick) begin
            ticks_left_reg <= ticks_left_reg - COUNT_BITS'(1);
            if (last_tick) begin
                move_dirs_reg   <= '0;
                event_total_reg <= '0;
            end
        end
    end

    // Output register: load on every accepted transfer, drop when taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            if (s_operation == OP_LOAD) begin
                step_bits_reg <= '0;
                dir_bits_reg  <= s_direction_bits;
                busy_reg      <= (top != '0);
            end else begin
                // A tick shows the directions it used, even on the last tick.
                step_bits_reg <= step_bits;
                dir_bits_reg  <= move_dirs_reg;
                busy_reg      <= do_tick ? !last_tick : 1'b0;
            end
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_step_bits = step_bits_reg;
    assign m_dir_bits  = dir_bits_reg;
    assign m_busy_res  = busy_reg;

    // Positions change only on an accepted transfer, which also reloads the
    // output register, so the lane registers serve directly as the result.
    assign m_pos_x = signed'(pos_arr[0]);
    assign m_pos_y = signed'(pos_arr[1]);
    assign m_pos_z = signed'(pos_arr[2]);
    assign m_pos_a = signed'(pos_arr[3]);
    assign m_pos_b = signed'(pos_arr[4]);
    assign m_pos_c = signed'(pos_arr[5]);

    // Busy flag of a result matches the remaining tick count.
    a_busy_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (m_busy_res == (ticks_left_reg != '0)))
        else $error("busy flag disagrees with remaining ticks");

    // A load never raises step pulses.
    a_load_no_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_operation == OP_LOAD)) |=> (m_step_bits == '0))
        else $error("step pulse on a load result");

    // A move never has more ticks left than its event total.
    a_ticks_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        ticks_left_reg <= event_total_reg)
        else $error("ticks left exceeds event total");

    // Positions of axes x and c hold while a result waits to be taken.
    a_pos_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> ($stable(m_pos_x) && $stable(m_pos_c)))
        else $error("position changed under a stalled result");

    // A step pulse is only possible while a move is under way.
    a_step_needs_move: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (ticks_left_reg == '0)) |=> (m_step_bits == '0))
        else $error("step pulse with no move in progress");

endmodule

`default_nettype wire
